// ===== hdl/lfna_pkg.sv =====
// Shared types, codes and helper functions for the lowest-free name allocator.
// No dependencies; every other file refers to it by scoped names.
package lfna_pkg;

    // Bitmap row geometry: one memory row holds this many slot bits
    localparam int ROW_BITS = 16;
    localparam int BIT_W    = 4;

    // Request kinds
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_REL   = 2'd1;
    localparam logic [1:0] MODE_BIND  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_pe;

    // Controller to datapath commands
    typedef struct packed {
        logic       clr;         // zero the row under the pointer, advance
        logic       take;        // capture the input word
        logic       load_hint;   // point at the first row that may hold a hole
        logic       load_idx;    // point at the row of the requested index
        logic       rd;          // read the row under the pointer
        logic       row_inc;
        logic       row_dec;
        logic       alloc_emit;  // mark lowest free bit used and send it
        logic       full_emit;   // send a table-full result
        logic       rel_clear;   // clear the requested bit
        logic       shrink_set;  // size from highest used bit of the row
        logic       bind_set;    // record requested index as bound
        logic       pend;        // latch status for a single result
        logic [1:0] pend_st;
        logic       emit_pend;   // send the single result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       zero_cnt;
        logic       idx_ok;
        logic       row_free;
        logic       row_last;
        logic       row_zero;
        logic       left_one;
        logic       is_top;
        logic       hi_found;
        logic       bit_used;
        logic       out_free;
    } t_sts;

    // Lowest set bit of a row
    function automatic t_pe pe_low(input logic [ROW_BITS-1:0] w);
        t_pe r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r.found = 1'b1;
                r.pos   = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Highest set bit of a row
    function automatic t_pe pe_high(input logic [ROW_BITS-1:0] w);
        t_pe r;
        r = '0;
        for (int i = 0; i < ROW_BITS; i++) begin
            if (w[i]) begin
                r.found = 1'b1;
                r.pos   = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/lowest_free_name_allocator_top.sv =====
// Top level of the lowest-free name allocator: stream ports, sequencer and datapath.
// Depends on lfna_pkg, lfna_ctrl and lfna_dp.
//
//  channel   direction  handshake                   payload
//  request   in         i_s_axis_tvalid/o_..tready  tuser: mode; tdata: count, index
//  result    out        o_m_axis_tvalid/i_..tready  tuser: status; tlast: last;
//                                                   tdata: name_out, bound_slot, table_size
//
// After reset a clearing pass over all ceil(SLOTS/16) rows zeroes the bitmap; no request is
// taken meanwhile. Allocate: take and decode, then a bitmap row read per row scanned from
// the hint row up, one read per name when a hole sits in the current row.
// Release: take, decode, read and clear, plus a read per row scanned downward when the top
// slot is freed. The bitmap memory port sets the pace.
// One output register holds a result; the block waits at emission until it is taken.
module lowest_free_name_allocator_top #(
    parameter int SLOTS     = 256,
    parameter int MAX_BATCH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [4:0] count, [12:5] index, zero fill
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] name_out, [15:8] bound_slot,
                                          // [24:16] table_size, zero fill
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast
);

    lfna_pkg::t_cmd cmd;
    lfna_pkg::t_sts sts;
    logic [7:0]     name;
    logic [7:0]     bound;
    logic [8:0]     size;

    lfna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfna_dp #(
        .SLOTS     (SLOTS),
        .MAX_BATCH (MAX_BATCH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_s_axis_tuser),
        .i_count     (i_s_axis_tdata[4:0]),
        .i_index     (i_s_axis_tdata[12:5]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_name      (name),
        .o_status    (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast),
        .o_bound     (bound),
        .o_size      (size)
    );

    assign o_m_axis_tdata = {7'd0, size, bound, name};

endmodule

// ===== hdl/lfna_ctrl.sv =====
// Sequencer for the allocator: clearing pass, request decode, row scans, emission.
// Depends on lfna_pkg for the command and status structs and the codes.
module lfna_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lfna_pkg::t_sts i_sts,
    output lfna_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLR       = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DEC       = 4'd2;
    localparam logic [3:0] S_ALLOC_RD  = 4'd3;
    localparam logic [3:0] S_ALLOC_CHK = 4'd4;
    localparam logic [3:0] S_REL_RD    = 4'd5;
    localparam logic [3:0] S_REL_CHK   = 4'd6;
    localparam logic [3:0] S_SHR_RD    = 4'd7;
    localparam logic [3:0] S_SHR_CHK   = 4'd8;
    localparam logic [3:0] S_BIND_RD   = 4'd9;
    localparam logic [3:0] S_BIND_CHK  = 4'd10;
    localparam logic [3:0] S_EMIT      = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.row_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.mode)
                    lfna_pkg::MODE_ALLOC: begin
                        if (i_sts.zero_cnt) begin
                            o_cmd.pend    = 1'b1;
                            o_cmd.pend_st = lfna_pkg::ST_INVALID;
                            n_state       = S_EMIT;
                        end else begin
                            o_cmd.load_hint = 1'b1;
                            n_state         = S_ALLOC_RD;
                        end
                    end
                    lfna_pkg::MODE_REL: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.load_idx = 1'b1;
                            n_state        = S_REL_RD;
                        end else begin
                            o_cmd.pend    = 1'b1;
                            o_cmd.pend_st = lfna_pkg::ST_INVALID;
                            n_state       = S_EMIT;
                        end
                    end
                    lfna_pkg::MODE_BIND: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.load_idx = 1'b1;
                            n_state        = S_BIND_RD;
                        end else begin
                            o_cmd.pend    = 1'b1;
                            o_cmd.pend_st = lfna_pkg::ST_INVALID;
                            n_state       = S_EMIT;
                        end
                    end
                    default: begin
                        o_cmd.pend    = 1'b1;
                        o_cmd.pend_st = lfna_pkg::ST_INVALID;
                        n_state       = S_EMIT;
                    end
                endcase
            end
            S_ALLOC_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (i_sts.row_free) begin
                    // hold the row word until the output register frees up
                    if (i_sts.out_free) begin
                        o_cmd.alloc_emit = 1'b1;
                        n_state = i_sts.left_one ? S_IDLE : S_ALLOC_RD;
                    end
                end else if (i_sts.row_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.full_emit = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = S_ALLOC_RD;
                end
            end
            S_REL_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_REL_CHK;
            end
            S_REL_CHK: begin
                o_cmd.rel_clear = 1'b1;
                if (!i_sts.is_top || i_sts.hi_found || i_sts.row_zero) begin
                    o_cmd.shrink_set = i_sts.is_top;
                    o_cmd.pend       = 1'b1;
                    o_cmd.pend_st    = lfna_pkg::ST_DONE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.row_dec = 1'b1;
                    n_state       = S_SHR_RD;
                end
            end
            S_SHR_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SHR_CHK;
            end
            S_SHR_CHK: begin
                if (i_sts.hi_found || i_sts.row_zero) begin
                    o_cmd.shrink_set = 1'b1;
                    o_cmd.pend       = 1'b1;
                    o_cmd.pend_st    = lfna_pkg::ST_DONE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.row_dec = 1'b1;
                    n_state       = S_SHR_RD;
                end
            end
            S_BIND_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_BIND_CHK;
            end
            S_BIND_CHK: begin
                o_cmd.pend = 1'b1;
                if (i_sts.bit_used) begin
                    o_cmd.bind_set = 1'b1;
                    o_cmd.pend_st  = lfna_pkg::ST_DONE;
                end else begin
                    o_cmd.pend_st  = lfna_pkg::ST_INVALID;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pend = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lfna_dp.sv =====
// Datapath: used bitmap memory in rows, size, bound slot, scan pointer, output register.
// Depends on lfna_pkg for commands, status, codes and the priority encoders.
module lfna_dp #(
    parameter int SLOTS     = 256,
    parameter int MAX_BATCH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lfna_pkg::t_cmd i_cmd,
    output lfna_pkg::t_sts o_sts,
    input  logic [1:0]     i_mode,
    input  logic [4:0]     i_count,
    input  logic [7:0]     i_index,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_name,
    output logic [1:0]     o_status,
    output logic           o_last,
    output logic [7:0]     o_bound,
    output logic [8:0]     o_size
);

    localparam int RB        = lfna_pkg::ROW_BITS;
    localparam int ROWS      = (SLOTS + RB - 1) / RB;
    localparam int RA_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SIZE_W    = $clog2(SLOTS + 1);
    localparam int CMP_W     = (SIZE_W > 9) ? SIZE_W : 9;
    localparam int LAST_N    = SLOTS - (ROWS - 1) * RB;
    localparam logic [RB:0]   LAST_ONE  = (RB + 1)'(1) << LAST_N;
    localparam logic [RB-1:0] LAST_MASK = RB'(LAST_ONE - (RB + 1)'(1));
    localparam logic [RA_W-1:0] ROW_LAST = RA_W'(ROWS - 1);
    localparam logic [RB-1:0]   ONE_BIT  = RB'(1);

    logic [RB-1:0]     r_mem [ROWS];
    logic [RB-1:0]     r_rdata;
    logic [RA_W-1:0]   r_row;
    logic [RA_W-1:0]   r_hint;
    logic [SIZE_W-1:0] r_size;
    logic [SLOT_W-1:0] r_cur;
    logic [1:0]        r_mode;
    logic [7:0]        r_index;
    logic [4:0]        r_left;
    logic [1:0]        r_pst;
    logic              r_out_valid;
    logic [7:0]        r_out_name;
    logic [1:0]        r_out_st;
    logic              r_out_last;
    logic [7:0]        r_out_bound;
    logic [8:0]        r_out_size;

    logic [4:0]                 eff_cnt;
    logic [SLOT_W-1:0]          idx_slot;
    logic [RA_W-1:0]            idx_row;
    logic [lfna_pkg::BIT_W-1:0] idx_bit;
    logic [RB-1:0]              idx_mask;
    logic [RB-1:0]              row_valid;
    logic [RB-1:0]              take_mask;
    logic                       same_row;
    lfna_pkg::t_pe              free_pe;
    lfna_pkg::t_pe              hi_pe;
    logic [SLOT_W-1:0]          take_slot;
    logic [SIZE_W-1:0]          take_size;
    logic [SIZE_W-1:0]          n_size_alloc;
    logic [SIZE_W-1:0]          hi_size;
    logic                       out_free;

    // Saturate oversized batches
    assign eff_cnt = (32'(i_count) > 32'(MAX_BATCH)) ? 5'(MAX_BATCH) : i_count;

    assign idx_slot  = SLOT_W'(r_index);
    assign idx_row   = RA_W'(idx_slot >> lfna_pkg::BIT_W);
    assign idx_bit   = lfna_pkg::BIT_W'(idx_slot);
    assign idx_mask  = ONE_BIT << idx_bit;
    assign row_valid = (r_row == ROW_LAST) ? LAST_MASK : '1;
    assign same_row  = (r_row == idx_row);

    // Bits past the table end count as used so the scan skips them
    assign free_pe   = lfna_pkg::pe_low(~r_rdata & row_valid);
    assign take_mask = ONE_BIT << free_pe.pos;
    assign take_slot = SLOT_W'({r_row, free_pe.pos});
    assign take_size = SIZE_W'({r_row, free_pe.pos});
    assign n_size_alloc = (take_size == r_size) ? r_size + SIZE_W'(1) : r_size;

    // The released bit reads back as free when its own row is examined
    assign hi_pe   = lfna_pkg::pe_high(r_rdata & ~(same_row ? idx_mask : '0));
    assign hi_size = SIZE_W'({r_row, hi_pe.pos}) + SIZE_W'(1);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts          = '0;
        o_sts.mode     = r_mode;
        o_sts.zero_cnt = (r_left == 5'd0);
        o_sts.idx_ok   = CMP_W'(r_index) < CMP_W'(r_size);
        o_sts.row_free = free_pe.found;
        o_sts.row_last = (r_row == ROW_LAST);
        o_sts.row_zero = (r_row == '0);
        o_sts.left_one = (r_left == 5'd1);
        o_sts.is_top   = (CMP_W'(r_index) + CMP_W'(1)) == CMP_W'(r_size);
        o_sts.hi_found = hi_pe.found;
        o_sts.bit_used = |(r_rdata & idx_mask);
        o_sts.out_free = out_free;
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_row] <= '0;
        end else if (i_cmd.alloc_emit) begin
            r_mem[r_row] <= r_rdata | take_mask;
        end else if (i_cmd.rel_clear) begin
            r_mem[r_row] <= r_rdata & ~idx_mask;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_hint <= '0;
            r_size <= '0;
            r_cur  <= '0;
        end else begin
            if (i_cmd.clr || i_cmd.row_inc) begin
                r_row <= r_row + RA_W'(1);
            end else if (i_cmd.row_dec) begin
                r_row <= r_row - RA_W'(1);
            end else if (i_cmd.load_hint) begin
                r_row <= r_hint;
            end else if (i_cmd.load_idx) begin
                r_row <= idx_row;
            end
            if (i_cmd.alloc_emit) begin
                r_hint <= r_row;
            end else if (i_cmd.rel_clear && (idx_row < r_hint)) begin
                r_hint <= idx_row;
            end
            if (i_cmd.alloc_emit) begin
                r_size <= n_size_alloc;
            end else if (i_cmd.shrink_set) begin
                r_size <= hi_pe.found ? hi_size : '0;
            end
            if (i_cmd.bind_set) begin
                r_cur <= idx_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= i_mode;
            r_index <= i_index;
            r_left  <= eff_cnt;
        end else if (i_cmd.alloc_emit) begin
            r_left  <= r_left - 5'd1;
        end
        if (i_cmd.pend) begin
            r_pst <= i_cmd.pend_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.alloc_emit || i_cmd.full_emit || i_cmd.emit_pend) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_emit) begin
            r_out_name  <= 8'(take_slot);
            r_out_st    <= lfna_pkg::ST_DONE;
            r_out_last  <= (r_left == 5'd1);
            r_out_bound <= 8'(r_cur);
            r_out_size  <= 9'(n_size_alloc);
        end else if (i_cmd.full_emit) begin
            r_out_name  <= 8'd0;
            r_out_st    <= lfna_pkg::ST_FULL;
            r_out_last  <= 1'b1;
            r_out_bound <= 8'(r_cur);
            r_out_size  <= 9'(r_size);
        end else if (i_cmd.emit_pend) begin
            r_out_name  <= (r_mode == lfna_pkg::MODE_ALLOC) ? 8'd0 : r_index;
            r_out_st    <= r_pst;
            r_out_last  <= 1'b1;
            r_out_bound <= 8'(r_cur);
            r_out_size  <= 9'(r_size);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_name      = r_out_name;
    assign o_status    = r_out_st;
    assign o_last      = r_out_last;
    assign o_bound     = r_out_bound;
    assign o_size      = r_out_size;

endmodule

// ===== hdl/lfna_chk.sv =====
// Port-level checker for the lowest-free name allocator, bound to the top level.
// Depends on lfna_pkg for the status codes.
module lfna_chk #(
    parameter int SLOTS = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("result word changed while stalled");

    // A full or rejected result always closes its request
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == lfna_pkg::ST_FULL ||
                             o_m_axis_tuser == lfna_pkg::ST_INVALID)) |-> o_m_axis_tlast)
        else $error("full or invalid result without last");

    // No request taken while the first result has not gone out is not required,
    // but no request may be taken while a result that is not the last of its batch is valid
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("request taken in the middle of a batch");

    // Table size never exceeds the slot count
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[24:16]) <= 32'(SLOTS)))
        else $error("table size beyond slot count");

    // Status is one of the defined codes; a full report names slot zero at full size
    a_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == lfna_pkg::ST_DONE || o_m_axis_tuser == lfna_pkg::ST_INVALID ||
             (o_m_axis_tuser == lfna_pkg::ST_FULL && o_m_axis_tdata[7:0] == 8'd0 &&
              o_m_axis_tdata[24:16] == 9'(SLOTS))))
        else $error("undefined status or malformed full report");

endmodule

bind lowest_free_name_allocator_top lfna_chk #(
    .SLOTS (SLOTS)
) u_lfna_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
